// File: hdl/evr_pkg.sv
`default_nettype none

package evr_pkg;

   localparam int VALUE_BITS            = 16;
   localparam int DURATION_BITS         = 16;
   localparam int FRACTION_BITS_DEFAULT = 16;

   typedef enum logic {
      FUNC_START = 1'b0,
      FUNC_TICK  = 1'b1
   } func_type;

   typedef struct packed {
      func_type                   func;
      logic signed [VALUE_BITS-1:0] target_value;
      logic [DURATION_BITS-1:0]     duration_ms;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] current_value;
      logic                         ramp_running;
   } rsp_type;

endpackage

`default_nettype wire

// File: hdl/eased_value_ramp_unit.sv
`default_nettype none

// channel   direction  ports                          transaction
// req       in         req_valid req_ready req_data   start or tick item
// rsp       out        rsp_valid rsp_ready rsp_data   eased value and running flag
//
// a start item, an idle tick or a final tick goes from idle straight to the done state
// a ramping tick runs the restoring divider, one quotient bit a cycle, then
// makes three passes through the one shared multiplier
// req_ready is high only while the sequencer is idle; rsp has its own register,
// so a new transaction may be taken while a result waits for rsp_ready
// synchronous reset clears the ramp state and both handshakes
module eased_value_ramp_unit #(
   parameter int FRACTION_BITS = evr_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire evr_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output evr_pkg::rsp_type      rsp_data
);

   localparam int VB = evr_pkg::VALUE_BITS;
   localparam int DB = evr_pkg::DURATION_BITS;
   localparam int FB = FRACTION_BITS;
   localparam int BW = FB + 2;
   localparam int AW = (VB + 1 > FB + 2) ? VB + 1 : FB + 2;
   localparam int PW = AW + BW;
   localparam int CW = $clog2(FB + 1);

   localparam logic [FB:0]          FIX_ONE  = (FB + 1)'(1) << FB;
   localparam logic signed [PW-1:0] HALF     = PW'(1) << (FB - 1);
   localparam logic signed [PW-1:0] HALF_LO  = (PW'(1) << (FB - 1)) - PW'(1);
   localparam logic [CW-1:0]        DIV_LAST = CW'(FB - 1);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DIV    = 7'b0000010,
      ST_SQUARE = 7'b0000100,
      ST_CUBE   = 7'b0001000,
      ST_EASE   = 7'b0010000,
      ST_SCALE  = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [VB-1:0] origin_ff, origin_in;
   logic signed [VB-1:0] goal_ff, goal_in;
   logic signed [VB-1:0] present_ff, present_in;
   logic [DB-1:0]        elapsed_ff, elapsed_in;
   logic [DB-1:0]        length_ff, length_in;
   logic                 active_ff, active_in;

   logic [DB-1:0]        rem_ff, rem_in;
   logic [FB-1:0]        quot_ff, quot_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [FB:0]          u_ff, u_in;
   logic signed [PW-1:0] prod_ff, prod_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   evr_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   logic [DB-1:0]        elapsed_next;
   logic [DB:0]          rem_shift;
   logic                 rem_fits;
   logic [FB:0]          u_calc;
   logic [FB:0]          prod_hi;
   logic signed [VB:0]   diff;
   logic signed [AW-1:0] mul_a;
   logic signed [BW-1:0] mul_b;
   logic signed [PW-1:0] mul_p;
   logic signed [PW-1:0] rnd;
   logic                 rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign elapsed_next = (elapsed_ff < length_ff) ? elapsed_ff + DB'(1) : elapsed_ff;
   assign rem_shift    = {rem_ff, 1'b0};
   assign rem_fits     = (rem_shift >= {1'b0, length_ff});
   assign u_calc       = FIX_ONE - {1'b0, quot_ff};
   assign prod_hi      = prod_ff[2*FB:FB];
   assign diff         = {goal_ff[VB-1], goal_ff} - {origin_ff[VB-1], origin_ff};
   assign rnd          = prod_ff + (prod_ff[PW-1] ? HALF_LO : HALF);

   // shared multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SQUARE: begin
            mul_a = AW'(u_calc);
            mul_b = BW'(u_calc);
         end
         ST_CUBE: begin
            mul_a = AW'(prod_hi);
            mul_b = BW'(u_ff);
         end
         ST_EASE: begin
            mul_a = AW'(diff);
            mul_b = BW'(FIX_ONE - prod_hi);
         end
         ST_IDLE, ST_DIV, ST_SCALE, ST_DONE: begin
            mul_a = '0;
            mul_b = '0;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = PW'(mul_a) * PW'(mul_b);

   always_comb begin
      state_in     = state_ff;
      origin_in    = origin_ff;
      goal_in      = goal_ff;
      present_in   = present_ff;
      elapsed_in   = elapsed_ff;
      length_in    = length_ff;
      active_in    = active_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      cnt_in       = cnt_ff;
      u_in         = u_ff;
      prod_in      = prod_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DONE;
               if (req_data.func == evr_pkg::FUNC_START) begin
                  origin_in  = present_ff;
                  goal_in    = req_data.target_value;
                  length_in  = req_data.duration_ms;
                  elapsed_in = '0;
                  active_in  = 1'b1;
               end else if (active_ff) begin
                  elapsed_in = elapsed_next;
                  if (elapsed_next >= length_ff) begin
                     present_in = goal_ff;
                     active_in  = 1'b0;
                  end else begin
                     rem_in   = elapsed_next;
                     cnt_in   = '0;
                     state_in = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit a cycle
            if (rem_fits) begin
               rem_in = DB'(rem_shift - {1'b0, length_ff});
            end else begin
               rem_in = rem_shift[DB-1:0];
            end
            quot_in = {quot_ff[FB-2:0], rem_fits};
            cnt_in  = cnt_ff + CW'(1);
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            u_in     = u_calc;
            prod_in  = mul_p;
            state_in = ST_CUBE;
         end
         ST_CUBE: begin
            prod_in  = mul_p;
            state_in = ST_EASE;
         end
         ST_EASE: begin
            prod_in  = mul_p;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            // round to nearest, ties away from zero
            present_in = origin_ff + rnd[FB+VB-1:FB];
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_data_in.current_value = present_ff;
               rsp_data_in.ramp_running  = active_ff;
               rsp_valid_in              = 1'b1;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         origin_ff    <= '0;
         goal_ff      <= '0;
         present_ff   <= '0;
         elapsed_ff   <= '0;
         length_ff    <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         origin_ff    <= origin_in;
         goal_ff      <= goal_in;
         present_ff   <= present_in;
         elapsed_ff   <= elapsed_in;
         length_ff    <= length_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      cnt_ff      <= cnt_in;
      u_ff        <= u_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// File: verif/ramp_checker.sv
module ramp_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire evr_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire evr_pkg::rsp_type rsp_data,
   output int                    fail_count,
   output int                    pending_count
);

   localparam int VB   = evr_pkg::VALUE_BITS;
   localparam int DB   = evr_pkg::DURATION_BITS;
   localparam int FRAC = evr_pkg::FRACTION_BITS_DEFAULT;
   localparam longint unsigned FIX_ONE = 64'd1 << FRAC;
   localparam longint FIX_HALF = longint'(1) << (FRAC - 1);

   logic signed [VB-1:0] start_value;
   logic signed [VB-1:0] goal_value;
   logic signed [VB-1:0] eased_value;
   logic [DB-1:0]        elapsed_ms;
   logic [DB-1:0]        length_ms;
   logic                 ramping;

   evr_pkg::rsp_type eased_results[$];
   int               mismatches = 0;

   assign fail_count = mismatches;

   function automatic evr_pkg::rsp_type advance_ramp(input evr_pkg::req_type item);
      longint unsigned  t_frac;
      longint unsigned  u;
      longint unsigned  u2;
      longint unsigned  u3;
      longint unsigned  ease;
      longint           diff;
      longint           prod;
      longint           mag;
      evr_pkg::rsp_type res;
      if (item.func == evr_pkg::FUNC_START) begin
         start_value = eased_value;
         goal_value  = item.target_value;
         length_ms   = item.duration_ms;
         elapsed_ms  = '0;
         ramping     = 1'b1;
      end else if (ramping) begin
         if (elapsed_ms < length_ms)
            elapsed_ms = elapsed_ms + 1'b1;
         if (elapsed_ms >= length_ms) begin
            eased_value = goal_value;
            ramping     = 1'b0;
         end else begin
            t_frac = (64'(elapsed_ms) << FRAC) / 64'(length_ms);
            u      = FIX_ONE - t_frac;
            u2     = (u * u) >> FRAC;
            u3     = (u2 * u) >> FRAC;
            ease   = FIX_ONE - u3;
            diff   = longint'(goal_value) - longint'(start_value);
            prod   = diff * longint'(ease);
            mag    = (prod < 0) ? -prod : prod;
            mag    = (mag + FIX_HALF) >> FRAC;
            if (prod < 0)
               mag = -mag;
            eased_value = VB'(longint'(start_value) + mag);
         end
      end
      res.current_value = eased_value;
      res.ramp_running  = ramping;
      return res;
   endfunction

   always @(posedge clock) begin
      evr_pkg::rsp_type want;
      if (reset) begin
         start_value = '0;
         goal_value  = '0;
         eased_value = '0;
         elapsed_ms  = '0;
         length_ms   = '0;
         ramping     = 1'b0;
         eased_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (eased_results.size() == 0) begin
               $display("%0t: result with nothing expected, got value %0d running %0b",
                        $time, rsp_data.current_value, rsp_data.ramp_running);
               mismatches++;
            end else begin
               want = eased_results.pop_front();
               if (rsp_data.current_value !== want.current_value) begin
                  $display("%0t: current_value expected %0d, got %0d",
                           $time, want.current_value, rsp_data.current_value);
                  mismatches++;
               end
               if (rsp_data.ramp_running !== want.ramp_running) begin
                  $display("%0t: ramp_running expected %0b, got %0b",
                           $time, want.ramp_running, rsp_data.ramp_running);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready)
            eased_results.push_back(advance_ramp(req_data));
      end
      pending_count <= eased_results.size();
   end

endmodule

// File: verif/tb_top.sv
module tb_top;

   localparam int VB           = evr_pkg::VALUE_BITS;
   localparam int DB           = evr_pkg::DURATION_BITS;
   localparam int ITEM_TARGET  = 1900;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AFTER   = 400;
   localparam int CALM_FIRST   = 900;
   localparam int CALM_LAST    = 1200;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   evr_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   evr_pkg::rsp_type rsp_data;

   int fail_count;
   int pending_count;
   int items_sent  = 0;
   int cycle_count = 0;
   int hold_left   = 0;
   bit hold_done   = 1'b0;
   bit calm        = 1'b0;

   eased_value_ramp_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   ramp_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("eased_value_ramp_unit regression: fail");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off to fill the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && items_sent >= HOLD_AFTER) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 8);
      end
   end

   task automatic send_item(input evr_pkg::func_type f,
                            input logic signed [VB-1:0] tgt,
                            input logic [DB-1:0] dur);
      evr_pkg::req_type item;
      item.func         = f;
      item.target_value = tgt;
      item.duration_ms  = dur;
      while (!calm && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      items_sent++;
   endtask

   initial begin
      logic signed [VB-1:0] goal;
      logic signed [VB-1:0] last_goal;
      logic [DB-1:0]        dur;
      bit                   goal_reached;
      int                   ticks;
      int                   pick;
      last_goal    = '0;
      goal_reached = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // tick while idle, zero length, shortest ramp, flat ramp
      send_item(evr_pkg::FUNC_TICK, 16'sh7fff, 16'hffff);
      send_item(evr_pkg::FUNC_START, 16'sh7fff, 16'd0);
      send_item(evr_pkg::FUNC_TICK, '0, '0);
      send_item(evr_pkg::FUNC_TICK, '0, '0);
      send_item(evr_pkg::FUNC_START, -16'sd32768, 16'd1);
      send_item(evr_pkg::FUNC_TICK, -16'sd1, 16'd1);
      send_item(evr_pkg::FUNC_START, -16'sd32768, 16'd2);
      send_item(evr_pkg::FUNC_TICK, '0, '0);
      send_item(evr_pkg::FUNC_TICK, '0, '0);
      // longest ramp, then restart while running
      send_item(evr_pkg::FUNC_START, 16'sh7fff, 16'hffff);
      send_item(evr_pkg::FUNC_TICK, '0, '0);
      send_item(evr_pkg::FUNC_TICK, '0, '0);
      send_item(evr_pkg::FUNC_START, '0, 16'd5);
      repeat (6) send_item(evr_pkg::FUNC_TICK, '0, '0);
      send_item(evr_pkg::FUNC_START, -16'sd32768, 16'd3);
      send_item(evr_pkg::FUNC_START, 16'sh7fff, 16'd4);
      repeat (4) send_item(evr_pkg::FUNC_TICK, '0, '0);

      while (items_sent < ITEM_TARGET) begin
         calm = (items_sent >= CALM_FIRST && items_sent < CALM_LAST);
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3))
               send_item(evr_pkg::FUNC_TICK, VB'($urandom), DB'($urandom));
         goal = (goal_reached && $urandom_range(0, 7) == 0) ? last_goal : VB'($urandom);
         pick = $urandom_range(0, 19);
         if (pick < 2)
            dur = DB'($urandom_range(0, 65535));
         else if (pick < 4)
            dur = '0;
         else if (pick < 6)
            dur = DB'($urandom_range(41, 120));
         else
            dur = DB'($urandom_range(1, 40));
         send_item(evr_pkg::FUNC_START, goal, dur);
         if (dur > 120)
            ticks = $urandom_range(1, 30);
         else if ($urandom_range(0, 5) == 0)
            ticks = $urandom_range(0, dur);
         else
            ticks = dur + $urandom_range(0, 3);
         repeat (ticks) send_item(evr_pkg::FUNC_TICK, VB'($urandom), DB'($urandom));
         goal_reached = (ticks != 0 && ticks >= dur);
         last_goal    = goal;
      end
      calm = 1'b0;

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("eased_value_ramp_unit regression: pass");
      else
         $display("eased_value_ramp_unit regression: fail");
      $finish;
   end

endmodule
